@@ rtl/cwra_pkg.sv @@
// shared types, register codes and sizes for the cache way run allocator
// no dependencies; imported by every module of the block
`default_nettype none
package cwra_pkg;

    localparam int MAX_MASK_BITS = 64;
    localparam int CFG_ADDR_W = 3;

    // register index codes (byte address bit 2)
    localparam logic CFG_CACHE_SIZE = 1'b0;
    localparam logic CFG_MASK_WIDTH = 1'b1;

    typedef struct packed {
        logic [63:0] free_mask;
        logic [30:0] request_size;
    } item_t;

    typedef struct packed {
        logic [63:0] largest_mask;
        logic [30:0] largest_bytes;
        logic [63:0] fit_mask;
        logic        fit_found;
    } result_t;

    // classified job handed from the front part to the back part
    typedef struct packed {
        logic [63:0] mask;
        logic [30:0] bin;
        logic [7:0]  need;
        logic        fit_en;
    } job_t;

    // configuration status seen by the front part
    typedef struct packed {
        logic [30:0] bin;
        logic [6:0]  width;
        logic        busy;
    } cfg_stat_t;

endpackage
`default_nettype wire

@@ rtl/cwra_cfg.sv @@
// configuration registers with apb access and a serial bin size divider
// depends on cwra_pkg
`default_nettype none
module cwra_cfg (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [cwra_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready,
    output cwra_pkg::cfg_stat_t                  stat
);
    import cwra_pkg::*;

    logic [30:0] cache_reg;
    logic [6:0]  width_reg;
    logic        busy_reg;
    logic        init_reg;
    logic [4:0]  cnt_reg;
    logic [6:0]  rem_reg;
    logic [30:0] quo_reg;
    logic [6:0]  wc;
    logic        wr;
    logic [7:0]  shifted;
    logic        qbit;
    logic [6:0]  rem_next;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    // clamp the width to one through the maximum
    always_comb
    begin
        if (width_reg == 7'd0)
            wc = 7'd1;
        else if (width_reg > 7'(MAX_MASK_BITS))
            wc = 7'(MAX_MASK_BITS);
        else
            wc = width_reg;
    end

    // register read back
    always_comb
    begin
        unique case (paddr[2])
            CFG_CACHE_SIZE: prdata = {1'b0, cache_reg};
            CFG_MASK_WIDTH: prdata = {25'd0, width_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // one restoring divide step per cycle
    always_comb
    begin
        shifted = {rem_reg, quo_reg[30]};
        qbit = (shifted >= {1'b0, wc});
        if (qbit)
            rem_next = 7'(shifted - {1'b0, wc});
        else
            rem_next = shifted[6:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cache_reg <= 31'd0;
            width_reg <= 7'(MAX_MASK_BITS);
            busy_reg  <= 1'b0;
            init_reg  <= 1'b0;
            cnt_reg   <= 5'd0;
            rem_reg   <= 7'd0;
            quo_reg   <= 31'd0;
        end
        else if (wr)
        begin
            unique case (paddr[2])
                CFG_CACHE_SIZE: cache_reg <= pwdata[30:0];
                CFG_MASK_WIDTH: width_reg <= pwdata[6:0];
                default:        cache_reg <= cache_reg;
            endcase
            busy_reg <= 1'b1;
            init_reg <= 1'b1;
        end
        else if (init_reg)
        begin
            init_reg <= 1'b0;
            quo_reg  <= cache_reg;
            rem_reg  <= 7'd0;
            cnt_reg  <= 5'd0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[29:0], qbit};
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == 5'd30)
                busy_reg <= 1'b0;
        end
    end

    assign stat.bin   = quo_reg;
    assign stat.width = wc;
    assign stat.busy  = busy_reg;

endmodule
`default_nettype wire

@@ rtl/cwra_front.sv @@
// front part: captures items, masks to the width and works out bins needed
// depends on cwra_pkg
`default_nettype none
module cwra_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire cwra_pkg::item_t     item,
    input  wire cwra_pkg::cfg_stat_t stat,
    output logic                     job_valid,
    input  wire logic                job_full,
    output cwra_pkg::job_t           job
);
    import cwra_pkg::*;

    localparam int FS = 8;

    typedef struct packed {
        logic [63:0] mask;
        logic [30:0] bin;
        logic [30:0] rem;
        logic [6:0]  quo;
        logic        over;
        logic        req_nz;
    } fstage_t;

    fstage_t    st_reg [FS];
    logic [FS-1:0] v_reg;
    fstage_t    st_next [FS];
    logic       en;
    logic       acc;
    logic [63:0] width_ones;
    logic [7:0] need;

    assign en   = !v_reg[FS-1] || !job_full;
    assign full = !en || stat.busy;
    assign acc  = push && !full;

    // capture stage and the quotient overflow check
    always_comb
    begin
        if (stat.width[6])
            width_ones = '1;
        else
            width_ones = (64'd1 << stat.width[5:0]) - 64'd1;
        st_next[0].mask   = item.free_mask & width_ones;
        st_next[0].bin    = stat.bin;
        st_next[0].rem    = item.request_size;
        st_next[0].quo    = 7'd0;
        st_next[0].over   = ({7'd0, item.request_size} >= {stat.bin, 7'd0});
        st_next[0].req_nz = (item.request_size != 31'd0);
    end

    // one quotient bit per stage, most significant first
    always_comb
    begin
        for (int s = 1; s < FS; s++)
        begin
            logic [37:0] dsh;
            dsh = {7'd0, st_reg[s-1].bin} << (FS - 1 - s);
            st_next[s] = st_reg[s-1];
            if ({7'd0, st_reg[s-1].rem} >= dsh)
            begin
                st_next[s].rem = 31'({7'd0, st_reg[s-1].rem} - dsh);
                st_next[s].quo[FS-1-s] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[FS-2:0], acc};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < FS; s++)
                st_reg[s] <= st_next[s];
        end
    end

    // round up and classify
    always_comb
    begin
        need = {1'b0, st_reg[FS-1].quo} + {7'd0, (st_reg[FS-1].rem != 31'd0)};
        job.mask   = st_reg[FS-1].mask;
        job.bin    = st_reg[FS-1].bin;
        job.need   = need;
        job.fit_en = st_reg[FS-1].req_nz && (st_reg[FS-1].bin != 31'd0) &&
                     !st_reg[FS-1].over && (need <= 8'(MAX_MASK_BITS));
    end

    assign job_valid = v_reg[FS-1] && !job_full;

endmodule
`default_nettype wire

@@ rtl/cwra_fifo.sv @@
// short job queue between the front and back parts
// depends on cwra_pkg
`default_nettype none
module cwra_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr,
    input  wire cwra_pkg::job_t wdata,
    output logic                qfull,
    input  wire logic           rd,
    output logic                qempty,
    output cwra_pkg::job_t      rdata
);
    import cwra_pkg::*;

    localparam int DEPTH = 4;

    job_t       buf_reg [DEPTH];
    logic [1:0] wp_reg;
    logic [1:0] rp_reg;
    logic [2:0] cnt_reg;

    assign qfull  = (cnt_reg == 3'(DEPTH));
    assign qempty = (cnt_reg == 3'd0);
    assign rdata  = buf_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 2'd0;
            rp_reg  <= 2'd0;
            cnt_reg <= 3'd0;
        end
        else
        begin
            if (wr)
                wp_reg <= wp_reg + 2'd1;
            if (rd)
                rp_reg <= rp_reg + 2'd1;
            if (wr && !rd)
                cnt_reg <= cnt_reg + 3'd1;
            else if (rd && !wr)
                cnt_reg <= cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            buf_reg[wp_reg] <= wdata;
    end

endmodule
`default_nettype wire

@@ rtl/cwra_back.sv @@
// back part: scans runs eight bits a stage and builds the result masks
// depends on cwra_pkg
`default_nettype none
module cwra_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           qempty,
    input  wire cwra_pkg::job_t job,
    output logic                qrd,
    output logic                empty,
    input  wire logic           pop,
    output cwra_pkg::result_t   result
);
    import cwra_pkg::*;

    localparam int BS = 8;
    localparam int BPS = MAX_MASK_BITS / BS;

    typedef struct packed {
        logic [63:0] mask;
        logic [30:0] bin;
        logic [7:0]  need;
        logic        fit_en;
        logic [6:0]  cur;
        logic [6:0]  best_len;
        logic [6:0]  best_end;
        logic        fit_ok;
        logic [6:0]  fit_len;
        logic [6:0]  fit_end;
    } scan_t;

    scan_t         st_reg [BS];
    scan_t         st_next [BS];
    logic [BS-1:0] v_reg;
    result_t       out_reg;
    logic          out_v_reg;
    logic          en;

    // one run step at position pos
    function automatic scan_t run_step(scan_t s, logic bitv, logic [6:0] pos);
        scan_t r;
        r = s;
        if (bitv)
        begin
            r.cur = s.cur + 7'd1;
            if (r.cur > s.best_len)
            begin
                r.best_len = r.cur;
                r.best_end = pos + 7'd1;
            end
        end
        else
        begin
            if (s.fit_en && s.cur != 7'd0 && {1'b0, s.cur} >= s.need &&
                (!s.fit_ok || s.cur < s.fit_len))
            begin
                r.fit_ok  = 1'b1;
                r.fit_len = s.cur;
                r.fit_end = pos;
            end
            r.cur = 7'd0;
        end
        return r;
    endfunction

    function automatic logic [63:0] run_mask(logic [6:0] len, logic [6:0] low);
        logic [63:0] m;
        if (len == 7'd0)
            m = 64'd0;
        else if (len[6])
            m = '1;
        else
            m = (64'd1 << len[5:0]) - 64'd1;
        return m << low[5:0];
    endfunction

    assign en    = !out_v_reg || pop;
    assign qrd   = en && !qempty;
    assign empty = !out_v_reg;

    // scan stages, the last one also closes the final run
    always_comb
    begin
        scan_t s0;
        s0.mask     = job.mask;
        s0.bin      = job.bin;
        s0.need     = job.need;
        s0.fit_en   = job.fit_en;
        s0.cur      = 7'd0;
        s0.best_len = 7'd0;
        s0.best_end = 7'd0;
        s0.fit_ok   = 1'b0;
        s0.fit_len  = 7'd0;
        s0.fit_end  = 7'd0;
        for (int j = 0; j < BS; j++)
        begin
            scan_t s;
            logic [6:0] pos;
            s = (j == 0) ? s0 : st_reg[j == 0 ? 0 : j-1];
            for (int k = 0; k < BPS; k++)
            begin
                pos = 7'(j * BPS + k);
                s = run_step(s, s.mask[pos[5:0]], pos);
            end
            if (j == BS - 1)
                s = run_step(s, 1'b0, 7'(MAX_MASK_BITS));
            st_next[j] = s;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg     <= '0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg     <= {v_reg[BS-2:0], !qempty};
            out_v_reg <= v_reg[BS-1];
        end
    end

    // scan stage registers and the result build from the final scan state
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < BS; j++)
                st_reg[j] <= st_next[j];
            out_reg.largest_mask <= run_mask(st_reg[BS-1].best_len,
                st_reg[BS-1].best_end - st_reg[BS-1].best_len);
            out_reg.largest_bytes <= 31'({31'd0, st_reg[BS-1].best_len} *
                                         {7'd0, st_reg[BS-1].bin});
            out_reg.fit_mask <= st_reg[BS-1].fit_ok ?
                run_mask(st_reg[BS-1].need[6:0],
                         st_reg[BS-1].fit_end - st_reg[BS-1].need[6:0]) : 64'd0;
            out_reg.fit_found <= st_reg[BS-1].fit_ok;
        end
    end

    assign result = out_reg;

endmodule
`default_nettype wire

@@ rtl/cache_way_run_allocator_core.sv @@
// an item passes the 8 stage request divider, the job queue, the 8 stage run scan
// and the output register on its way to the ports; one item per cycle while full
// is low
// a write to either register starts a bin update (one load, 31 divide steps);
// full stays high until it finishes
// reset clears all valid bits and queues; cache_size 0, mask_width 64, bin 0
`default_nettype none
module cache_way_run_allocator_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  wire cwra_pkg::item_t                 item,
    output logic                                 empty,
    input  wire logic                            pop,
    output cwra_pkg::result_t                    result,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [cwra_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready
);
    import cwra_pkg::*;

    cfg_stat_t stat;
    job_t      fjob;
    job_t      bjob;
    logic      jwr;
    logic      jfull;
    logic      jrd;
    logic      jempty;

    cwra_cfg u_cfg (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .stat
    );

    cwra_front u_front (
        .clk, .rst_n, .push, .full, .item, .stat,
        .job_valid(jwr), .job_full(jfull), .job(fjob)
    );

    cwra_fifo u_fifo (
        .clk, .rst_n, .wr(jwr), .wdata(fjob), .qfull(jfull),
        .rd(jrd), .qempty(jempty), .rdata(bjob)
    );

    cwra_back u_back (
        .clk, .rst_n, .qempty(jempty), .job(bjob), .qrd(jrd),
        .empty, .pop, .result
    );

endmodule
`default_nettype wire

@@ rtl/cwra_checker.sv @@
// port level checks for the cache way run allocator, bound to the top level
// depends on cwra_pkg
`default_nettype none
module cwra_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            empty,
    input wire logic                            pop,
    input wire cwra_pkg::result_t               result
);
    import cwra_pkg::*;

    logic [63:0] lm;
    assign lm = result.largest_mask;

    // found flag agrees with the fit mask
    a_found: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.fit_found |-> result.fit_mask != 64'd0)
        else $error("fit_found set with empty fit mask");

    a_nofit: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !result.fit_found |-> result.fit_mask == 64'd0)
        else $error("fit mask set without fit_found");

    // longest run mask is one contiguous run
    a_contig: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((lm + (lm & (~lm + 64'd1))) & lm) == 64'd0)
        else $error("largest mask not contiguous");

    // a waiting item holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result))
        else $error("waiting result changed");

endmodule

bind cache_way_run_allocator_core cwra_checker u_cwra_checker (
    .clk, .rst_n, .empty, .pop, .result
);
`default_nettype wire
